>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request codes,
// register indexes, blank cell words and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int CELL_W     = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int COLOR_W    = 4;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CLEAR  = 16'h0720;
    localparam logic [CELL_W-1:0] BLANK_SCROLL = 16'h0F20;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_word;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic                 scrolled;
    } t_rsp;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_SCROLL = 6'b000100,
        S_FILL   = 6'b001000,
        S_PUT    = 6'b010000,
        S_READ   = 6'b100000
    } t_state;

endpackage

>>> hdl/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: request type, character byte and cell address.
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::REQ_W-1:0]  req_type;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::IDX_W-1:0]  cell_index;

    modport source (output valid, req_type, char_code, cell_index, input ready);
    modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

>>> hdl/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: cell word, cursor position and scroll flag.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CELL_W-1:0]    cell_word;
    logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
    logic [tcw_pkg::COL_OUT_W-1:0] cursor_col;
    logic                          scrolled;

    modport source (output valid, cell_word, cursor_row, cursor_col, scrolled,
                    input ready);
    modport sink   (input valid, cell_word, cursor_row, cursor_col, scrolled,
                    output ready);
endinterface

>>> hdl/tcw_cfg_if.sv
// ----------------------------------------------------------------------------
// tcw_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CFG_IDX_W-1:0] idx;
    logic [tcw_pkg::COLOR_W-1:0]   data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

>>> hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 2000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console writer: screen store in one RAM, row/column cursor, scroll,
// clear and read of single cells.
// ----------------------------------------------------------------------------
// put without scroll: result registered in the cycle after the transaction,
//   one put per cycle while the receiver takes each result; read: RAM data,
//   then result registered; clear: S_CLEAR blanks every cell; put with
//   scroll: copy rows and refill the bottom row one cell per cycle through
//   the single RAM write port; reset: a clearing pass blanks ROWS*COLS cells
//   (2000 by default); requests wait for it, register writes are taken at once
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tcw_req_if.sink   i_req,
    tcw_rsp_if.source o_rsp,
    tcw_cfg_if.sink   i_cfg
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CUW   = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLS);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic              r_cp_vld, n_cp_vld;
    logic [AW-1:0]     r_cp_addr, n_cp_addr;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [CUW-1:0]    r_addr, n_addr;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_clr_resp, n_clr_resp;
    logic              r_rd_oob, n_rd_oob;
    logic              r_out_vld, n_out_vld;
    t_rsp              r_out, n_out;
    logic [COLOR_W-1:0] r_fg, r_bg;

    logic              acc;
    logic [CHAR_W-1:0] p_char;
    logic              p_nl;
    logic [RW-1:0]     p_row;
    logic [CW-1:0]     p_col;
    logic [CUW-1:0]    p_addr;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] rdata;

    tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign acc         = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.cell_word  = r_out.cell_word;
    assign o_rsp.cursor_row = r_out.cursor_row;
    assign o_rsp.cursor_col = r_out.cursor_col;
    assign o_rsp.scrolled   = r_out.scrolled;

    // cursor step of a put, the scroll already done
    always_comb begin
        p_char = (r_state == S_PUT) ? r_char : i_req.char_code;
        p_nl   = (p_char == NEWLINE_CODE);
        if (p_nl) begin
            p_row  = r_row + RW'(1);
            p_col  = '0;
            p_addr = r_addr - CUW'(r_col) + CUW'(COLS);
        end else if (r_col == CW'(COLS - 1)) begin
            p_row  = r_row + RW'(1);
            p_col  = '0;
            p_addr = r_addr + CUW'(1);
        end else begin
            p_row  = r_row;
            p_col  = r_col + CW'(1);
            p_addr = r_addr + CUW'(1);
        end
    end

    // ram ports
    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = BLANK_CLEAR;
        priority if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_cp_vld) begin
            we    = 1'b1;
            waddr = r_cp_addr;
            wdata = rdata;
        end else if (r_state == S_FILL) begin
            we    = 1'b1;
            wdata = BLANK_SCROLL;
        end else if ((r_state == S_PUT || (acc && i_req.req_type == REQ_PUT
                      && r_row != RW'(ROWS))) && !p_nl) begin
            we    = 1'b1;
            waddr = r_addr[AW-1:0];
            wdata = {r_bg, r_fg, p_char};
        end else begin
            we    = 1'b0;
        end

        re    = (r_state == S_SCROLL) || (acc && i_req.req_type == REQ_READ);
        raddr = (r_state == S_SCROLL) ? r_cnt + AW'(COLS) : AW'(i_req.cell_index);
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cp_vld   = (r_state == S_SCROLL);
        n_cp_addr  = r_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_addr     = r_addr;
        n_char     = r_char;
        n_clr_resp = r_clr_resp;
        n_rd_oob   = r_rd_oob;
        n_out_vld  = r_out_vld;
        n_out      = r_out;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt      = '0;
                    n_state    = S_IDLE;
                    n_clr_resp = 1'b0;
                    if (r_clr_resp) begin
                        n_out_vld = 1'b1;
                        n_out     = '{'0, ROW_OUT_W'(r_row), COL_OUT_W'(r_col), 1'b0};
                    end
                end
            end
            S_IDLE: begin
                if (acc) begin
                    unique case (i_req.req_type)
                        REQ_PUT: begin
                            if (r_row == RW'(ROWS)) begin
                                n_row   = RW'(ROWS - 1);
                                n_addr  = r_addr - CUW'(COLS);
                                n_char  = i_req.char_code;
                                n_cnt   = '0;
                                n_state = S_SCROLL;
                            end else begin
                                n_row     = p_row;
                                n_col     = p_col;
                                n_addr    = p_addr;
                                n_out_vld = 1'b1;
                                n_out     = '{'0, ROW_OUT_W'(p_row), COL_OUT_W'(p_col), 1'b0};
                            end
                        end
                        REQ_READ: begin
                            n_rd_oob = (32'(i_req.cell_index) >= CELLS);
                            n_state  = S_READ;
                        end
                        REQ_CLEAR: begin
                            n_cnt      = '0;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                            n_out     = '{'0, ROW_OUT_W'(r_row), COL_OUT_W'(r_col), 1'b0};
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(CELLS - COLS - 1)) begin
                    n_cnt   = AW'(CELLS - COLS);
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (!r_cp_vld) begin
                    n_cnt = r_cnt + AW'(1);
                    if (r_cnt == AW'(CELLS - 1)) begin
                        n_cnt   = '0;
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                n_row     = p_row;
                n_col     = p_col;
                n_addr    = p_addr;
                n_out_vld = 1'b1;
                n_out     = '{'0, ROW_OUT_W'(p_row), COL_OUT_W'(p_col), 1'b1};
                n_state   = S_IDLE;
            end
            S_READ: begin
                n_out_vld = 1'b1;
                n_out     = '{r_rd_oob ? '0 : rdata, ROW_OUT_W'(r_row),
                              COL_OUT_W'(r_col), 1'b0};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_cp_vld   <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_addr     <= '0;
            r_clr_resp <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_cp_vld   <= n_cp_vld;
            r_row      <= n_row;
            r_col      <= n_col;
            r_addr     <= n_addr;
            r_clr_resp <= n_clr_resp;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        r_char    <= n_char;
        r_rd_oob  <= n_rd_oob;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.idx == CFG_FG) begin
                r_fg <= i_cfg.data;
            end else if (i_cfg.idx == CFG_BG) begin
                r_bg <= i_cfg.data;
            end
        end
    end

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (32'(waddr) < CELLS))
        else $error("ram write beyond the screen");

    a_cursor_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_addr) == 32'(r_row) * COLS + 32'(r_col))
        else $error("linear cursor out of step with row and column");

    a_past_end_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == RW'(ROWS)) |-> (r_col == '0))
        else $error("cursor past the last row with nonzero column");

    a_read_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_out_vld)
        else $error("read transaction without a result");

endmodule

>>> tb/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console writer. A behavioral copy of the
// screen store, cursor and color registers predicts every response. Directed
// tests cover reset contents, colors, clear and scroll. Random phases follow,
// with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    localparam logic [REQ_W-1:0]     REQ_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int MAX_REPORTS  = 40;
    localparam int DRAIN_SETTLE = 8;
    localparam int PHASE_ITEMS  = 120;
    localparam int PAUSE_EVERY  = 40;

    logic i_clk;
    logic i_rst_n;

    tcw_req_if req_if ();
    tcw_rsp_if rsp_if ();
    tcw_cfg_if cfg_if ();

    text_console_writer_core #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    logic [CELL_W-1:0]  screen_model [CELLS];
    int                 cursor_pos;
    logic [COLOR_W-1:0] fg_model;
    logic [COLOR_W-1:0] bg_model;

    t_rsp expected_rsp_q [$];
    t_rsp head_rsp;
    int   errors;
    int   send_idle_pct;
    int   rsp_stall_pct;
    int   newline_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // console behavior applied to one request, returns its response
    function automatic t_rsp console_apply(input logic [REQ_W-1:0] req,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic [IDX_W-1:0] idx);
        t_rsp r;
        int   k;
        r = '0;
        case (req)
            REQ_PUT: begin
                if (cursor_pos >= CELLS) begin
                    for (k = 0; k < CELLS - COLS; k++) begin
                        screen_model[k] = screen_model[k + COLS];
                    end
                    for (k = CELLS - COLS; k < CELLS; k++) begin
                        screen_model[k] = BLANK_SCROLL;
                    end
                    cursor_pos -= COLS;
                    r.scrolled = 1'b1;
                end
                if (ch == NEWLINE_CODE) begin
                    cursor_pos = (cursor_pos / COLS + 1) * COLS;
                end else begin
                    if (cursor_pos < CELLS) begin
                        screen_model[cursor_pos] = {bg_model, fg_model, ch};
                    end
                    cursor_pos++;
                end
            end
            REQ_READ: begin
                if (idx < CELLS) begin
                    r.cell_word = screen_model[idx];
                end
            end
            REQ_CLEAR: begin
                for (k = 0; k < CELLS; k++) begin
                    screen_model[k] = BLANK_CLEAR;
                end
            end
            default: ;
        endcase
        r.cursor_row = ROW_OUT_W'(cursor_pos / COLS);
        r.cursor_col = COL_OUT_W'(cursor_pos % COLS);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CELL_W-1:0] expv,
                                        input logic [CELL_W-1:0] actv);
        if (actv !== expv) begin
            if (errors < MAX_REPORTS) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, expv, actv);
            end
            errors++;
        end
    endfunction

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t mismatch: response with none expected, actual %h %0d %0d %b",
                             $time, rsp_if.cell_word, rsp_if.cursor_row, rsp_if.cursor_col,
                             rsp_if.scrolled);
                end
                errors++;
            end else begin
                head_rsp = expected_rsp_q.pop_front();
                check_field("cell_word", head_rsp.cell_word, rsp_if.cell_word);
                check_field("cursor_row", CELL_W'(head_rsp.cursor_row),
                            CELL_W'(rsp_if.cursor_row));
                check_field("cursor_col", CELL_W'(head_rsp.cursor_col),
                            CELL_W'(rsp_if.cursor_col));
                check_field("scrolled", CELL_W'(head_rsp.scrolled), CELL_W'(rsp_if.scrolled));
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= req;
        req_if.char_code  <= ch;
        req_if.cell_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        expected_rsp_q.push_back(console_apply(req, ch, idx));
    endtask

    task automatic req_release();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        req_release();
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_FG) begin
            fg_model = data;
        end else if (idx == CFG_BG) begin
            bg_model = data;
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random_request();
        int                roll;
        int                back;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        roll = $urandom_range(99);
        ch   = CHAR_W'($urandom);
        idx  = IDX_W'($urandom);
        if (roll < 62) begin
            if ($urandom_range(99) < newline_pct) begin
                ch = NEWLINE_CODE;
            end
            send_request(REQ_PUT, ch, idx);
        end else if (roll < 92) begin
            case ($urandom_range(3))
                0, 1: begin
                    back = $urandom_range(cursor_pos > 160 ? 160 : cursor_pos);
                    idx  = IDX_W'(cursor_pos - back);
                end
                2: idx = IDX_W'($urandom_range(CELLS - 1));
                default: begin
                    if ($urandom_range(1)) begin
                        idx = IDX_W'($urandom_range((1 << IDX_W) - 1, CELLS));
                    end
                end
            endcase
            send_request(REQ_READ, ch, idx);
        end else if (roll < 94) begin
            send_request(REQ_CLEAR, ch, idx);
        end else begin
            send_request(REQ_UNUSED, ch, idx);
        end
    endtask

    task automatic test_reset_state();
        send_request(REQ_READ, 8'h00, '0);
        send_request(REQ_READ, 8'hFF, IDX_W'(CELLS - 1));
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS));
        send_request(REQ_READ, 8'h00, '1);
        send_request(REQ_UNUSED, 8'hFF, '1);
    endtask

    task automatic test_put_colors();
        wait_drain();
        cfg_write(CFG_FG, 4'h0);
        cfg_write(CFG_BG, 4'hF);
        send_request(REQ_PUT, 8'hFF, '1);
        send_request(REQ_PUT, 8'h80, '0);
        send_request(REQ_PUT, 8'h00, '0);
        wait_drain();
        // spare register indexes must not touch the colors
        cfg_write(CFG_SPARE_A, 4'h5);
        cfg_write(CFG_SPARE_B, 4'hA);
        send_request(REQ_PUT, 8'h41, '0);
        send_request(REQ_PUT, NEWLINE_CODE, '0);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1);
        send_request(REQ_READ, 8'h00, 11'd2);
        send_request(REQ_READ, 8'h00, 11'd3);
    endtask

    task automatic test_clear();
        send_request(REQ_PUT, 8'h7F, '0);
        send_request(REQ_CLEAR, 8'hFF, '1);
        send_request(REQ_READ, 8'h00, '0);
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS - 1));
        send_request(REQ_PUT, 8'h42, '0);
        send_request(REQ_READ, 8'h00, IDX_W'(cursor_pos - 1));
    endtask

    task automatic test_scroll();
        wait_drain();
        cfg_write(CFG_FG, 4'h0);
        cfg_write(CFG_BG, 4'h0);
        while (cursor_pos < CELLS) send_request(REQ_PUT, NEWLINE_CODE, '0);
        send_request(REQ_PUT, 8'h5A, '0);
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS - COLS));
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS - 1));
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS - COLS - 1));
        send_request(REQ_PUT, NEWLINE_CODE, '0);
        // newline while past the last cell scrolls first
        send_request(REQ_PUT, NEWLINE_CODE, '0);
        send_request(REQ_PUT, 8'h7E, '0);
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS - 2 * COLS));
        send_request(REQ_READ, 8'h00, IDX_W'(CELLS - COLS));
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int nl_pct,
                                    input logic [COLOR_W-1:0] fg,
                                    input logic [COLOR_W-1:0] bg);
        int k;
        wait_drain();
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        newline_pct   = nl_pct;
        cfg_write(CFG_FG, fg);
        cfg_write(CFG_BG, bg);
        for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k > 0 && k % PAUSE_EVERY == 0) begin
                wait_drain();
                if ($urandom_range(1)) begin
                    cfg_write(CFG_IDX_W'($urandom), COLOR_W'($urandom));
                end
            end
            send_random_request();
        end
    endtask

    initial begin
        int k;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_PUT;
        req_if.char_code  = '0;
        req_if.cell_index = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.idx        = CFG_FG;
        cfg_if.data       = '0;
        errors            = 0;
        send_idle_pct     = 0;
        rsp_stall_pct     = 0;
        newline_pct       = 12;
        for (k = 0; k < CELLS; k++) begin
            screen_model[k] = BLANK_CLEAR;
        end
        cursor_pos = 0;
        fg_model   = FG_RESET;
        bg_model   = BG_RESET;
        i_rst_n    = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_put_colors();
        test_clear();
        test_scroll();
        run_random_phase(0, 0, 12, 4'h0, 4'h0);
        run_random_phase(65, 0, 2, 4'hF, 4'hF);
        run_random_phase(0, 65, 12, COLOR_W'($urandom), COLOR_W'($urandom));
        run_random_phase(31, 31, 25, COLOR_W'($urandom), COLOR_W'($urandom));

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/tcw_pkg.sv
hdl/tcw_req_if.sv
hdl/tcw_rsp_if.sv
hdl/tcw_cfg_if.sv
hdl/tcw_ram.sv
hdl/text_console_writer_core.sv
tb/tb_text_console_writer_core.sv
